[src/ilmq_pkg.sv]
package ilmq_pkg;

  localparam int MODE_W = 2;
  localparam int LIST_W = 4;
  localparam int SLOT_W = 6;

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HEAD,
    ST_POP,
    ST_UNLINK_HEAD,
    ST_WALK,
    ST_SPLICE,
    ST_TERM,
    ST_RESP
  } ctrl_state_t;

endpackage

[src/ilmq_ram.sv]
module ilmq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ilmq_ctrl.sv]
module ilmq_ctrl
  import ilmq_pkg::*;
#(
  parameter int SLOTS = 64,
  parameter int CPUS  = 8,
  localparam int NLISTS = 3 + CPUS,
  localparam int SW     = $clog2(SLOTS),
  localparam int W      = $clog2(SLOTS + 1),
  localparam int HW     = $clog2(NLISTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [LIST_W-1:0] in_list,
  input  logic [SLOT_W-1:0] in_slot,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [SLOT_W-1:0] res_slot,
  output logic              res_ok,
  output logic              lk_we,
  output logic [SW-1:0]     lk_waddr,
  output logic [W-1:0]      lk_wdata,
  output logic              lk_re,
  output logic [SW-1:0]     lk_raddr,
  input  logic [W-1:0]      lk_rdata,
  output logic              hd_we,
  output logic [HW-1:0]     hd_waddr,
  output logic [W-1:0]      hd_wdata,
  output logic              hd_re,
  output logic [HW-1:0]     hd_raddr,
  input  logic [W-1:0]      hd_rdata
);

  localparam int CLR_N = (SLOTS > NLISTS) ? SLOTS : NLISTS;
  localparam int CLRW  = $clog2(CLR_N);
  localparam logic [W-1:0]    NONE     = W'(SLOTS);
  localparam logic [SW-1:0]   LAST_CNT = SW'(SLOTS - 1);
  localparam logic [CLRW-1:0] LAST_CLR = CLRW'(CLR_N - 1);

  ctrl_state_t state, state_next;
  logic [MODE_W-1:0] op, op_next;
  logic [HW-1:0]     lid, lid_next;
  logic [W-1:0]      sl, sl_next;
  logic [W-1:0]      cur, cur_next;
  logic [SW-1:0]     cnt, cnt_next;
  logic [CLRW-1:0]   clr, clr_next;
  logic [SLOT_W-1:0] res_slot_next;
  logic              res_ok_next;

  logic [31:0] in_slot32, in_list32, sl32, cur32, clr32, clr32p1;
  logic        list_ok, slot_ok, mode_ok;

  assign in_slot32 = 32'(in_slot);
  assign in_list32 = 32'(in_list);
  assign sl32      = 32'(sl);
  assign cur32     = 32'(cur);
  assign clr32     = 32'(clr);
  assign clr32p1   = clr32 + 32'd1;
  assign list_ok   = in_list32 < 32'(NLISTS);
  assign slot_ok   = in_slot32 < 32'(SLOTS);
  assign mode_ok   = (in_mode == MODE_PUSH) || (in_mode == MODE_POP) || (in_mode == MODE_DEL);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_RESP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    lid      <= lid_next;
    sl       <= sl_next;
    cur      <= cur_next;
    cnt      <= cnt_next;
    res_slot <= res_slot_next;
    res_ok   <= res_ok_next;
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    lid_next      = lid;
    sl_next       = sl;
    cur_next      = cur;
    cnt_next      = cnt;
    clr_next      = clr;
    res_slot_next = res_slot;
    res_ok_next   = res_ok;
    lk_we         = 1'b0;
    lk_waddr      = sl[SW-1:0];
    lk_wdata      = NONE;
    lk_re         = 1'b0;
    lk_raddr      = cur[SW-1:0];
    hd_we         = 1'b0;
    hd_waddr      = lid;
    hd_wdata      = sl;
    hd_re         = 1'b0;
    hd_raddr      = in_list32[HW-1:0];

    unique case (state)
      ST_CLEAR: begin
        // rebuild the reset chain: slot i links to i+1, only list 0 owns slots
        if (clr32 < 32'(SLOTS)) begin
          lk_we    = 1'b1;
          lk_waddr = clr32[SW-1:0];
          lk_wdata = clr32p1[W-1:0];
        end
        if (clr32 < 32'(NLISTS)) begin
          hd_we    = 1'b1;
          hd_waddr = clr32[HW-1:0];
          hd_wdata = (clr == '0) ? '0 : NONE;
        end
        clr_next = clr + CLRW'(1);
        if (clr == LAST_CLR) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_next  = in_mode;
          lid_next = in_list32[HW-1:0];
          sl_next  = in_slot32[W-1:0];
          if (!list_ok || !mode_ok || (in_mode != MODE_POP && !slot_ok)) begin
            res_ok_next   = 1'b0;
            res_slot_next = '0;
            state_next    = ST_RESP;
          end else begin
            hd_re      = 1'b1;
            state_next = ST_HEAD;
          end
        end
      end

      ST_HEAD: begin
        cur_next      = hd_rdata;
        cnt_next      = '0;
        res_ok_next   = 1'b0;
        res_slot_next = '0;
        state_next    = ST_RESP;
        case (op)
          MODE_POP: begin
            if (hd_rdata < NONE) begin
              lk_re      = 1'b1;
              lk_raddr   = hd_rdata[SW-1:0];
              state_next = ST_POP;
            end
          end
          MODE_PUSH: begin
            if (hd_rdata >= NONE) begin
              hd_we         = 1'b1;
              lk_we         = 1'b1;
              res_ok_next   = 1'b1;
              res_slot_next = sl32[SLOT_W-1:0];
            end else if (hd_rdata != sl) begin
              lk_re      = 1'b1;
              lk_raddr   = hd_rdata[SW-1:0];
              state_next = ST_WALK;
            end
          end
          MODE_DEL: begin
            if (hd_rdata < NONE) begin
              lk_re = 1'b1;
              if (hd_rdata == sl) begin
                lk_raddr   = sl[SW-1:0];
                state_next = ST_UNLINK_HEAD;
              end else begin
                lk_raddr   = hd_rdata[SW-1:0];
                state_next = ST_WALK;
              end
            end
          end
          default: begin
          end
        endcase
      end

      ST_POP: begin
        hd_we         = 1'b1;
        hd_wdata      = lk_rdata;
        lk_we         = 1'b1;
        lk_waddr      = cur[SW-1:0];
        res_ok_next   = 1'b1;
        res_slot_next = cur32[SLOT_W-1:0];
        state_next    = ST_RESP;
      end

      ST_UNLINK_HEAD: begin
        hd_we         = 1'b1;
        hd_wdata      = lk_rdata;
        lk_we         = 1'b1;
        res_ok_next   = 1'b1;
        res_slot_next = sl32[SLOT_W-1:0];
        state_next    = ST_RESP;
      end

      ST_WALK: begin
        // lk_rdata is the successor of cur
        res_ok_next   = 1'b0;
        res_slot_next = '0;
        if (op == MODE_PUSH && lk_rdata >= NONE) begin
          lk_we      = 1'b1;
          lk_waddr   = cur[SW-1:0];
          lk_wdata   = sl;
          state_next = ST_TERM;
        end else if (op != MODE_PUSH && lk_rdata >= NONE) begin
          state_next = ST_RESP;
        end else if (lk_rdata == sl) begin
          if (op == MODE_PUSH) begin
            state_next = ST_RESP;
          end else begin
            lk_re      = 1'b1;
            lk_raddr   = sl[SW-1:0];
            state_next = ST_SPLICE;
          end
        end else if (cnt == LAST_CNT) begin
          // chain loops back on itself
          state_next = ST_RESP;
        end else begin
          cur_next = lk_rdata;
          cnt_next = cnt + SW'(1);
          lk_re    = 1'b1;
          lk_raddr = lk_rdata[SW-1:0];
        end
      end

      ST_SPLICE: begin
        lk_we      = 1'b1;
        lk_waddr   = cur[SW-1:0];
        lk_wdata   = lk_rdata;
        state_next = ST_TERM;
      end

      ST_TERM: begin
        lk_we         = 1'b1;
        res_ok_next   = 1'b1;
        res_slot_next = sl32[SLOT_W-1:0];
        state_next    = ST_RESP;
      end

      ST_RESP: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/index_linked_multi_queue.sv]
// a word rejected on its fields goes straight to the result state; push onto an empty list or
//   a failure seen at the head is decided after the head read, pop and delete of the head after a link read
// push and delete walk the list one link per cycle, and a link counter stops a walk
//   on a chain that loops back on itself
// the result sits in an output register, so the next word is taken while it waits
// rst is synchronous; then a clearing pass over all link and head entries with s_tready low
module index_linked_multi_queue
  import ilmq_pkg::*;
#(
  parameter int SLOTS = 64,
  parameter int CPUS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // mode[1:0], list_id[5:2], slot[11:6], zero[15:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // slot_out[5:0], ok[6], zero[7]
);

  localparam int NLISTS = 3 + CPUS;
  localparam int SW     = $clog2(SLOTS);
  localparam int W      = $clog2(SLOTS + 1);
  localparam int HW     = $clog2(NLISTS);

  logic              res_valid, res_ready, res_ok;
  logic [SLOT_W-1:0] res_slot;
  logic [SLOT_W-1:0] out_slot;
  logic              out_ok;

  logic          lk_we, lk_re;
  logic [SW-1:0] lk_waddr, lk_raddr;
  logic [W-1:0]  lk_wdata, lk_rdata;
  logic          hd_we, hd_re;
  logic [HW-1:0] hd_waddr, hd_raddr;
  logic [W-1:0]  hd_wdata, hd_rdata;

  ilmq_ctrl #(
    .SLOTS (SLOTS),
    .CPUS  (CPUS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tdata[1:0]),
    .in_list   (s_tdata[5:2]),
    .in_slot   (s_tdata[11:6]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_slot  (res_slot),
    .res_ok    (res_ok),
    .lk_we     (lk_we),
    .lk_waddr  (lk_waddr),
    .lk_wdata  (lk_wdata),
    .lk_re     (lk_re),
    .lk_raddr  (lk_raddr),
    .lk_rdata  (lk_rdata),
    .hd_we     (hd_we),
    .hd_waddr  (hd_waddr),
    .hd_wdata  (hd_wdata),
    .hd_re     (hd_re),
    .hd_raddr  (hd_raddr),
    .hd_rdata  (hd_rdata)
  );

  ilmq_ram #(
    .DEPTH (SLOTS),
    .WIDTH (W)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  ilmq_ram #(
    .DEPTH (NLISTS),
    .WIDTH (W)
  ) u_head_ram (
    .clk   (clk),
    .we    (hd_we),
    .waddr (hd_waddr),
    .wdata (hd_wdata),
    .re    (hd_re),
    .raddr (hd_raddr),
    .rdata (hd_rdata)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_slot <= res_slot;
      out_ok   <= res_ok;
    end
  end

  assign m_tdata = {1'b0, out_ok, out_slot};

endmodule
